>>> design/led_stripe_pulse_encoder_assert.svh
// Assertion helpers for the LED stripe pulse encoder.
// Bodies use the clk and rst_n of the module that expands them.
`ifndef LED_STRIPE_PULSE_ENCODER_ASSERT_SVH
`define LED_STRIPE_PULSE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define LSPE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define LSPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define LSPE_ASSERT_IMPL(label, ante, cons)

`define LSPE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/lspe_pkg.sv
package lspe_pkg;

  // item queues before and after the sequencer
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_LATCH     = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // one tick as seen by the sequencer
  typedef struct packed {
    logic       offer;
    logic [7:0] data;
    logic       last;
  } tick_t;

  typedef struct packed {
    logic line_level;
    logic byte_taken;
    logic busy;
  } res_t;

endpackage

>>> design/lspe_front.sv
module lspe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_offer_valid,
  input  logic [7:0]        in_offer_byte,
  input  logic              in_offer_last,
  output lspe_pkg::tick_t   q_tick,
  output logic              q_valid,
  input  logic              q_take
);

  lspe_pkg::tick_t                 mem_r [lspe_pkg::Q_DEPTH];
  logic [lspe_pkg::Q_AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [lspe_pkg::Q_CW-1:0]       cnt_r, cnt_nxt;
  lspe_pkg::tick_t                 cls;
  logic                            push_ok, pop_ok;

  assign in_full = (cnt_r == lspe_pkg::Q_CW'(lspe_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tick  = mem_r[rd_ptr_r];
  assign push_ok = in_push & ~in_full;
  assign pop_ok  = q_take & q_valid;

  // payload of a tick with no offer is don't-care; clear it so the back end sees one form
  always_comb begin
    cls.offer = in_offer_valid;
    cls.data  = in_offer_valid ? in_offer_byte : 8'd0;
    cls.last  = in_offer_valid & in_offer_last;
  end

  always_comb begin
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + lspe_pkg::Q_CW'(1);
      2'b01:   cnt_nxt = cnt_r - lspe_pkg::Q_CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wr_ptr_r <= wr_ptr_r + lspe_pkg::Q_AW'(1);
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + lspe_pkg::Q_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= cls;
  end

endmodule

>>> design/lspe_back.sv
module lspe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lspe_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [lspe_pkg::CFG_DW-1:0]   cfg_wdata,
  input  lspe_pkg::tick_t               q_tick,
  input  logic                          q_valid,
  output logic                          q_take,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_line_level,
  output logic                          out_byte_taken,
  output logic                          out_busy_res
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  logic [7:0]  zero_high_r, zero_low_r, one_high_r, one_low_r;
  logic [15:0] latch_r;

  logic [1:0]  ph_r, ph_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [7:0]  sb_r, sb_nxt;
  logic [3:0]  bl_r, bl_nxt;
  logic        pe_r, pe_nxt;
  logic        taken, rdy;
  lspe_pkg::res_t res;

  lspe_pkg::res_t                  oq_r [lspe_pkg::Q_DEPTH];
  logic [lspe_pkg::Q_AW-1:0]       owr_r, ord_r;
  logic [lspe_pkg::Q_CW-1:0]       ocnt_r, ocnt_nxt;
  logic                            step, opop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= 8'd7;
      zero_low_r  <= 8'd18;
      one_high_r  <= 8'd18;
      one_low_r   <= 8'd7;
      latch_r     <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lspe_pkg::CFG_ZERO_HIGH: zero_high_r <= cfg_wdata[7:0];
        lspe_pkg::CFG_ZERO_LOW:  zero_low_r  <= cfg_wdata[7:0];
        lspe_pkg::CFG_ONE_HIGH:  one_high_r  <= cfg_wdata[7:0];
        lspe_pkg::CFG_ONE_LOW:   one_low_r   <= cfg_wdata[7:0];
        lspe_pkg::CFG_LATCH:     latch_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one tick of the pulse sequencer
  always_comb begin
    ph_nxt = ph_r;
    tl_nxt = tl_r;
    sb_nxt = sb_r;
    bl_nxt = bl_r;
    pe_nxt = pe_r;
    taken  = 1'b0;

    priority if (ph_r == PH_HIGH && tl_r == '0) begin
      ph_nxt = PH_LOW;
      tl_nxt = {8'd0, sb_r[7] ? one_low_r : zero_low_r};
    end else if (ph_r == PH_LOW && tl_r == '0) begin
      if (bl_r > 4'd1) begin
        sb_nxt = {sb_r[6:0], 1'b0};
        bl_nxt = bl_r - 4'd1;
        ph_nxt = PH_HIGH;
        tl_nxt = {8'd0, sb_r[6] ? one_high_r : zero_high_r};
      end else begin
        bl_nxt = 4'd0;
        if (pe_r) begin
          pe_nxt = 1'b0;
          ph_nxt = PH_LATCH;
          tl_nxt = latch_r;
        end
      end
    end else if (ph_r == PH_LATCH && tl_r == '0) begin
      ph_nxt = PH_IDLE;
    end else begin
    end

    rdy = (ph_nxt == PH_IDLE) ||
          (ph_nxt == PH_LOW && tl_nxt == '0 && bl_nxt == '0 && !pe_nxt);

    if (rdy && q_tick.offer) begin
      taken  = 1'b1;
      sb_nxt = q_tick.data;
      bl_nxt = lspe_pkg::BITS_PER_BYTE;
      pe_nxt = q_tick.last;
      ph_nxt = PH_HIGH;
      tl_nxt = {8'd0, q_tick.data[7] ? one_high_r : zero_high_r};
    end

    res.line_level = (ph_nxt == PH_HIGH);
    res.byte_taken = taken;
    res.busy       = (ph_nxt != PH_IDLE);

    if (tl_nxt != '0) tl_nxt = tl_nxt - 16'd1;
  end

  // step whenever a tick is waiting and the result queue has room
  assign step   = q_valid && (ocnt_r != lspe_pkg::Q_CW'(lspe_pkg::Q_DEPTH));
  assign q_take = step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      tl_r <= '0;
      bl_r <= '0;
      pe_r <= 1'b0;
    end else if (step) begin
      ph_r <= ph_nxt;
      tl_r <= tl_nxt;
      bl_r <= bl_nxt;
      pe_r <= pe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) sb_r <= sb_nxt;
  end

  assign out_empty = (ocnt_r == '0);
  assign opop      = out_pop & ~out_empty;
  assign out_line_level = oq_r[ord_r].line_level;
  assign out_byte_taken = oq_r[ord_r].byte_taken;
  assign out_busy_res   = oq_r[ord_r].busy;

  always_comb begin
    unique case ({step, opop})
      2'b10:   ocnt_nxt = ocnt_r + lspe_pkg::Q_CW'(1);
      2'b01:   ocnt_nxt = ocnt_r - lspe_pkg::Q_CW'(1);
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (step) owr_r <= owr_r + lspe_pkg::Q_AW'(1);
      if (opop) ord_r <= ord_r + lspe_pkg::Q_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step) oq_r[owr_r] <= res;
  end

endmodule

>>> design/led_stripe_pulse_encoder.sv
// One-wire LED stripe pulse encoder. Every input beat is one timing tick and yields exactly
// one result beat (line level, byte taken, busy). A byte offered while the encoder is ready
// is sent MSB first, each bit as a high pulse then a low pulse whose lengths come from the
// zero/one tick registers; after the byte marked last the line is held low for latch_r
// ticks. Ticks are taken at one per clock for as long as results are popped. The sequencer
// steps on a tick while it sits at the head of the input queue and writes its result into a
// two-deep result queue whose head drives the result ports. Registers must be written only
// while no ticks are in flight.
`include "led_stripe_pulse_encoder_assert.svh"

module led_stripe_pulse_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_offer_valid,
  input  logic [7:0]                    in_offer_byte,
  input  logic                          in_offer_last,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_line_level,
  output logic                          out_byte_taken,
  output logic                          out_busy_res,
  input  logic                          cfg_we,
  input  logic [lspe_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [lspe_pkg::CFG_DW-1:0]   cfg_wdata
);

  lspe_pkg::tick_t q_tick;
  logic            q_valid;
  logic            q_take;

  lspe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_offer_valid (in_offer_valid),
    .in_offer_byte  (in_offer_byte),
    .in_offer_last  (in_offer_last),
    .q_tick         (q_tick),
    .q_valid        (q_valid),
    .q_take         (q_take)
  );

  lspe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_tick         (q_tick),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_line_level (out_line_level),
    .out_byte_taken (out_byte_taken),
    .out_busy_res   (out_busy_res)
  );

  `LSPE_ASSERT_IMPL(a_take_needs_tick, q_take, q_valid)
  `LSPE_ASSERT_IMPL(a_taken_is_busy, !out_empty && out_byte_taken, out_busy_res)
  `LSPE_ASSERT_IMPL(a_high_is_busy, !out_empty && out_line_level, out_busy_res)
  `LSPE_ASSERT_NEXT(a_take_fills_out, q_take, !out_empty)

endmodule
